// ----- sv/grid_cover_cell_search_core_assert.svh -----
// Assertion macros shared by the grid cover cell search RTL.
`ifndef GRID_COVER_CELL_SEARCH_CORE_ASSERT_SVH
`define GRID_COVER_CELL_SEARCH_CORE_ASSERT_SVH
`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define GCCS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define GCCS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define GCCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GCCS_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define GCCS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define GCCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/gccs_pkg.sv -----
// Types, constants and helpers shared by the grid cover cell search modules.
`timescale 1ns / 1ps
package gccs_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = 7;
  localparam int CMD_W   = 2;
  localparam int SIDES_W = 4;
  localparam int IDX_W   = 12;
  localparam int D2_W    = 13;
  // Row load counter runs one row above and below the row at hand.
  localparam int LZ_W    = $clog2(MAX_HEIGHT + 3);
  localparam int CMP_W   = (LZ_W > DIM_W) ? LZ_W + 1 : DIM_W + 1;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam int SIDE_PX = 0;
  localparam int SIDE_MX = 1;
  localparam int SIDE_PZ = 2;
  localparam int SIDE_MZ = 3;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_SEARCH
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             blocked;
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } grid_dims_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_CAP,
    ST_SCAN,
    ST_DONE
  } back_state_t;

  // Map a raw size register onto 1..vmax.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] vmax);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > vmax) r = vmax;
    return r;
  endfunction

endpackage

// ----- sv/grid_cover_cell_search_core.sv -----
// Top level of the grid cover cell search: config registers and stage wiring.
`timescale 1ns / 1ps
// Write: the beat passes the front register and the queue before its bit is written to memory; no result beat.
// Point query: three row reads, each through ST_LOAD_RD and ST_LOAD_CAP, then ST_DONE loads the result.
// Nearest search: one grid cell per cycle in the scan loop, which pauses for a row read between grid rows.
// Throughput is set by the back stage, which runs one operation at a time.
// Reset (rst, synchronous): size registers to 64, then a clearing pass over all MAX_HEIGHT rows
// sweeps the occupancy memory one row a cycle; in_ready stays low.
module grid_cover_cell_search_core import gccs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [COL_W-1:0]   col,
  input  logic [ROW_W-1:0]   row,
  input  logic               blocked_bit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [SIDES_W-1:0] cover_sides,
  output logic [IDX_W-1:0]   cell_index,
  output logic [D2_W-1:0]    distance_sq,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [DIM_W-1:0]   cfg_data
);

  // Raw size registers, as written.
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;

  // Sizes in use: zero acts as one, anything above the maximum acts as the maximum.
  grid_dims_t dims;

  logic clearing;
  logic f_valid, f_take;
  op_t  f_op;
  logic q_ready, q_valid, q_pop;
  op_t  q_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(64);
      grid_height <= DIM_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  grid_width  <= cfg_data;
        CFG_IDX_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dims.width  = clamp_dim(grid_width, DIM_W'(MAX_WIDTH));
  assign dims.height = clamp_dim(grid_height, DIM_W'(MAX_HEIGHT));

  // Hand a decoded beat to the queue whenever it has room.
  assign f_take = f_valid && q_ready;

  // Front: take input beats, drop command 3 and off-grid writes.
  gccs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .col         (col),
    .row         (row),
    .blocked_bit (blocked_bit),
    .dims        (dims),
    .clearing    (clearing),
    .f_valid     (f_valid),
    .f_op        (f_op),
    .f_take      (f_take)
  );

  // Queue: lets the front keep accepting while the back is busy on a search.
  gccs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_take),
    .push_op    (f_op),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_op     (q_op),
    .pop        (q_pop)
  );

  // Back: occupancy memory, three-row window, scan loop and output register.
  gccs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .dims        (dims),
    .clearing    (clearing),
    .q_valid     (q_valid),
    .q_op        (q_op),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .cover_sides (cover_sides),
    .cell_index  (cell_index),
    .distance_sq (distance_sq)
  );

endmodule

// ----- sv/gccs_front.sv -----
// Front stage: accept input beats, decode commands, drop no-op items.
`timescale 1ns / 1ps
module gccs_front import gccs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] command,
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  input  logic             blocked_bit,
  input  grid_dims_t       dims,
  input  logic             clearing,
  output logic             f_valid,
  output op_t              f_op,
  input  logic             f_take
);

  logic keep;
  logic in_range;
  op_t  dec_op;

  assign in_ready = !clearing && (!f_valid || f_take);
  assign in_range = (CMP_W'(col) < CMP_W'(dims.width)) && (CMP_W'(row) < CMP_W'(dims.height));

  always_comb begin
    dec_op.col     = col;
    dec_op.row     = row;
    dec_op.blocked = blocked_bit;
    unique case (command)
      CMD_WRITE: begin
        dec_op.kind = OP_WRITE;
        keep        = in_range;
      end
      CMD_QUERY: begin
        dec_op.kind = OP_QUERY;
        keep        = 1'b1;
      end
      CMD_SEARCH: begin
        dec_op.kind = OP_SEARCH;
        keep        = 1'b1;
      end
      default: begin
        dec_op.kind = OP_WRITE;
        keep        = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= keep;
    end else if (f_take) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_op <= dec_op;
    end
  end

endmodule

// ----- sv/gccs_queue.sv -----
// Short operation queue between the front and back stages.
`timescale 1ns / 1ps
`include "grid_cover_cell_search_core_assert.svh"
module gccs_queue import gccs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic push_ready,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop
);

  op_t              entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign push_ready = (count != QCNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  `GCCS_ASSERT_ALWAYS(a_q_bound, clk, rst, count <= QCNT_W'(Q_DEPTH), "queue overfilled")
  `GCCS_ASSERT_NEXT(a_q_hold, clk, rst, push && !pop, count != '0, "queue lost a beat")

endmodule

// ----- sv/gccs_back.sv -----
// Back stage: occupancy memory, clearing pass, writes, point queries, nearest search.
`timescale 1ns / 1ps
`include "grid_cover_cell_search_core_assert.svh"
module gccs_back import gccs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  grid_dims_t         dims,
  output logic               clearing,
  input  logic               q_valid,
  input  op_t                q_op,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [SIDES_W-1:0] cover_sides,
  output logic [IDX_W-1:0]   cell_index,
  output logic [D2_W-1:0]    distance_sq
);

  back_state_t state, state_next;

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_data;
  logic [MAX_WIDTH-1:0] col_mask;
  logic [MAX_WIDTH-1:0] win_up, win_mid, win_dn;
  logic [ROW_W-1:0]     clr_row;
  logic [ROW_W-1:0]     rd_addr;

  logic             is_search;
  logic [COL_W-1:0] org_col, x_cnt;
  logic [ROW_W-1:0] org_row, z_cnt;
  logic [LZ_W-1:0]  load_z;
  logic [1:0]       load_left;
  logic             cap_ok;
  logic [IDX_W-1:0] row_base;

  logic               best_found;
  logic [SIDES_W-1:0] best_sides;
  logic [IDX_W-1:0]   near_idx;
  logic [D2_W-1:0]    best_d2;

  logic rd_en, bit_we, out_load, load_row_ok, last_x, last_z, better;

  logic [COL_W-1:0]   cell_x, x_plus, x_minus, dx_abs;
  logic [ROW_W-1:0]   cell_z, dz_abs;
  logic [2*COL_W-1:0] dx_sq;
  logic [2*ROW_W-1:0] dz_sq;
  logic [D2_W-1:0]    d2;
  logic [IDX_W-1:0]   cell_idx;
  logic               cell_in;
  logic [SIDES_W-1:0] raw_sides, cell_sides;

  // Column mask keeps bits beyond the grid width reading as free.
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      col_mask[i] = (CMP_W'(i) < CMP_W'(dims.width));
    end
  end

  // load_z holds the row number plus one, so zero stands for the row above row 0.
  assign load_row_ok = (load_z != '0) && (CMP_W'(load_z) <= CMP_W'(dims.height));
  assign rd_addr     = ROW_W'(load_z - LZ_W'(1));

  assign cell_x  = is_search ? x_cnt : org_col;
  assign cell_z  = is_search ? z_cnt : org_row;
  assign x_plus  = cell_x + COL_W'(1);
  assign x_minus = cell_x - COL_W'(1);
  assign cell_in = (CMP_W'(cell_x) < CMP_W'(dims.width)) &&
                   (CMP_W'(cell_z) < CMP_W'(dims.height));

  always_comb begin
    raw_sides          = '0;
    raw_sides[SIDE_PX] = (cell_x != COL_W'(MAX_WIDTH - 1)) && win_mid[x_plus];
    raw_sides[SIDE_MX] = (cell_x != '0) && win_mid[x_minus];
    raw_sides[SIDE_PZ] = win_dn[cell_x];
    raw_sides[SIDE_MZ] = win_up[cell_x];
    cell_sides         = (cell_in && !win_mid[cell_x]) ? raw_sides : '0;
  end

  assign dx_abs   = (cell_x >= org_col) ? cell_x - org_col : org_col - cell_x;
  assign dz_abs   = (cell_z >= org_row) ? cell_z - org_row : org_row - cell_z;
  assign dx_sq    = dx_abs * dx_abs;
  assign dz_sq    = dz_abs * dz_abs;
  assign d2       = D2_W'(dx_sq) + D2_W'(dz_sq);
  assign cell_idx = row_base + IDX_W'(x_cnt);
  assign better   = (cell_sides != '0) && (!best_found || d2 < best_d2);

  assign last_x = (CMP_W'(x_cnt) == CMP_W'(dims.width) - CMP_W'(1));
  assign last_z = (CMP_W'(z_cnt) == CMP_W'(dims.height) - CMP_W'(1));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_row == ROW_W'(MAX_HEIGHT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid && q_op.kind != OP_WRITE) state_next = ST_LOAD_RD;
      end
      ST_LOAD_RD: begin
        state_next = ST_LOAD_CAP;
      end
      ST_LOAD_CAP: begin
        if (load_left == 2'd1) state_next = is_search ? ST_SCAN : ST_DONE;
        else state_next = ST_LOAD_RD;
      end
      ST_SCAN: begin
        if (last_x) state_next = last_z ? ST_DONE : ST_LOAD_RD;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    clearing = (state == ST_CLEAR);
    q_pop    = (state == ST_IDLE) && q_valid;
    bit_we   = q_pop && (q_op.kind == OP_WRITE);
    rd_en    = (state == ST_LOAD_RD) && load_row_ok;
    out_load = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_row <= clr_row + ROW_W'(1);
    end
  end

  // Occupancy memory: one row per word, bit writes, registered read.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_row] <= '0;
    end else if (bit_we) begin
      mem[q_op.row][q_op.col] <= q_op.blocked;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_op.kind != OP_WRITE) begin
      is_search  <= (q_op.kind == OP_SEARCH);
      org_col    <= q_op.col;
      org_row    <= q_op.row;
      load_z     <= (q_op.kind == OP_SEARCH) ? '0 : LZ_W'(q_op.row);
      load_left  <= 2'd3;
      x_cnt      <= '0;
      z_cnt      <= '0;
      row_base   <= '0;
      best_found <= 1'b0;
      best_sides <= '0;
      near_idx   <= '0;
      best_d2    <= '0;
    end
    if (state == ST_LOAD_RD) begin
      cap_ok <= load_row_ok;
    end
    if (state == ST_LOAD_CAP) begin
      win_up    <= win_mid;
      win_mid   <= win_dn;
      win_dn    <= cap_ok ? (rd_data & col_mask) : '0;
      load_z    <= load_z + LZ_W'(1);
      load_left <= load_left - 2'd1;
    end
    if (state == ST_SCAN) begin
      if (better) begin
        best_found <= 1'b1;
        best_sides <= cell_sides;
        near_idx   <= cell_idx;
        best_d2    <= d2;
      end
      if (last_x) begin
        x_cnt <= '0;
        if (!last_z) begin
          z_cnt     <= z_cnt + ROW_W'(1);
          row_base  <= row_base + IDX_W'(dims.width);
          load_left <= 2'd1;
        end
      end else begin
        x_cnt <= x_cnt + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (is_search) begin
        found       <= best_found;
        cover_sides <= best_sides;
        cell_index  <= near_idx;
        distance_sq <= best_d2;
      end else begin
        found       <= (cell_sides != '0);
        cover_sides <= cell_sides;
        cell_index  <= '0;
        distance_sq <= '0;
      end
    end
  end

  `GCCS_ASSERT_NEXT(a_done_hold, clk, rst, (state == ST_DONE) && out_valid && !out_ready, state == ST_DONE, "result dropped while output full")
  `GCCS_ASSERT_IMPLIES(a_scan_mode, clk, rst, state == ST_SCAN, is_search, "scan outside a search")
  `GCCS_ASSERT_NEXT(a_query_done, clk, rst, (state == ST_LOAD_CAP) && (load_left == 2'd1) && !is_search, state == ST_DONE, "query did not finish after its rows")

endmodule
